// ===== rtl/core/stereo_peak_bar_meter_core_macros.svh =====
// ----------------------------------------------------------------------------
// Stereo peak bar meter assertion macros
// Property shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef STEREO_PEAK_BAR_METER_CORE_MACROS_SVH
`define STEREO_PEAK_BAR_METER_CORE_MACROS_SVH

// same-cycle implication
`define SPBM_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SPBM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/spbm_pkg.sv =====
// ----------------------------------------------------------------------------
// Stereo peak bar meter package
// Request types, block record, register indexes and segment codes.
// ----------------------------------------------------------------------------
package spbm_pkg;

  typedef struct packed {
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
  } in_req_t;

  typedef struct packed {
    logic [5:0] segment_index;
    logic [1:0] segment_colour;
    logic [1:0] segment_glyph;
    logic       last_segment;
  } out_req_t;

  // finished block: final peaks of both channels
  typedef struct packed {
    logic [15:0] left_peak;
    logic [15:0] right_peak;
  } blk_t;

  typedef struct packed {
    logic valid;
    blk_t blk;
  } blk_push_t;

  typedef struct packed {
    logic valid;
    blk_t blk;
  } blk_head_t;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned FPB_W      = 13;
  localparam int unsigned CNT_W      = 12;

  localparam logic [CFG_IDX_W-1:0] REG_FRAMES_PER_BLOCK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_THRESHOLD   = 2'd2;

  localparam logic [FPB_W-1:0] FPB_RESET  = 13'd512;
  localparam logic [FPB_W-1:0] FPB_MAX    = 13'd4096;
  localparam logic [15:0]      LOW_RESET  = 16'd10813;
  localparam logic [15:0]      HIGH_RESET = 16'd21955;

  localparam logic [1:0] COL_DARK   = 2'd0;
  localparam logic [1:0] COL_GREEN  = 2'd1;
  localparam logic [1:0] COL_YELLOW = 2'd2;
  localparam logic [1:0] COL_RED    = 2'd3;

  localparam logic [1:0] GLY_BLANK = 2'd0;
  localparam logic [1:0] GLY_BOTH  = 2'd1;
  localparam logic [1:0] GLY_LEFT  = 2'd2;
  localparam logic [1:0] GLY_RIGHT = 2'd3;

endpackage

// ===== rtl/core/stereo_peak_bar_meter_core.sv =====
// ----------------------------------------------------------------------------
// Stereo peak bar meter core
// Timing: a block's peaks are registered in the queue, then its first segment request in the back end.
// Throughput: one frame per cycle while the queue has room; one segment request per cycle
//   while the output is not stalled, from the single segment walker behind a two-block queue.
// Reset: asynchronous, active low; clears peaks, frame count, queue and output valid,
//   and loads the register reset values.
// ----------------------------------------------------------------------------
module stereo_peak_bar_meter_core #(
  parameter int unsigned BAR_SEGMENTS = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  spbm_pkg::in_req_t                   in_req_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output spbm_pkg::out_req_t                  out_req_o,
  input  logic                                cfg_we_i,
  input  logic [spbm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [spbm_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  logic [spbm_pkg::FPB_W-1:0] fpb_q, fpb_d;
  logic [15:0]                low_q, low_d;
  logic [15:0]                high_q, high_d;
  spbm_pkg::blk_push_t        push;
  spbm_pkg::blk_head_t        head;
  logic                       q_full, pop;

  always_comb begin
    fpb_d  = fpb_q;
    low_d  = low_q;
    high_d = high_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        spbm_pkg::REG_FRAMES_PER_BLOCK: fpb_d  = cfg_data_i[spbm_pkg::FPB_W-1:0];
        spbm_pkg::REG_LOW_THRESHOLD:    low_d  = cfg_data_i;
        spbm_pkg::REG_HIGH_THRESHOLD:   high_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fpb_q  <= spbm_pkg::FPB_RESET;
      low_q  <= spbm_pkg::LOW_RESET;
      high_q <= spbm_pkg::HIGH_RESET;
    end else begin
      fpb_q  <= fpb_d;
      low_q  <= low_d;
      high_q <= high_d;
    end
  end

  spbm_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .in_req_i           (in_req_i),
    .frames_per_block_i (fpb_q),
    .q_full_i           (q_full),
    .push_o             (push)
  );

  spbm_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (q_full),
    .head_o (head),
    .pop_i  (pop)
  );

  spbm_back #(
    .BAR_SEGMENTS (BAR_SEGMENTS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (head),
    .pop_o            (pop),
    .low_threshold_i  (low_q),
    .high_threshold_i (high_q),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_req_o        (out_req_o)
  );

endmodule

// ===== rtl/core/spbm_front.sv =====
// ----------------------------------------------------------------------------
// Stereo peak bar meter front end
// Tracks per-channel peaks over a block and hands finished blocks on.
// ----------------------------------------------------------------------------
module spbm_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  spbm_pkg::in_req_t                  in_req_i,
  input  logic [spbm_pkg::FPB_W-1:0]         frames_per_block_i,
  input  logic                               q_full_i,
  output spbm_pkg::blk_push_t                push_o
);

  logic [15:0]                 left_peak_q, left_peak_d;
  logic [15:0]                 right_peak_q, right_peak_d;
  logic [spbm_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [spbm_pkg::FPB_W-1:0]  len;
  logic [spbm_pkg::FPB_W-1:0]  cnt_inc;
  logic [15:0]                 l_mag, r_mag, l_max, r_max;
  logic                        accept, blk_end;

  function automatic logic [15:0] mag16(logic [15:0] v);
    logic [16:0] m;
    m = v[15] ? (17'h10000 - {1'b0, v}) : {1'b0, v};
    return (m > 17'd32767) ? 16'd32767 : m[15:0];
  endfunction

  assign l_mag = mag16(in_req_i.left_sample);
  assign r_mag = mag16(in_req_i.right_sample);
  assign l_max = (l_mag > left_peak_q)  ? l_mag : left_peak_q;
  assign r_max = (r_mag > right_peak_q) ? r_mag : right_peak_q;

  always_comb begin
    if (frames_per_block_i == '0) begin
      len = spbm_pkg::FPB_W'(1);
    end else if (frames_per_block_i > spbm_pkg::FPB_MAX) begin
      len = spbm_pkg::FPB_MAX;
    end else begin
      len = frames_per_block_i;
    end
  end

  assign cnt_inc    = {1'b0, cnt_q} + spbm_pkg::FPB_W'(1);
  assign blk_end    = cnt_inc >= len;
  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  assign push_o.valid          = accept && blk_end;
  assign push_o.blk.left_peak  = l_max;
  assign push_o.blk.right_peak = r_max;

  always_comb begin
    left_peak_d  = left_peak_q;
    right_peak_d = right_peak_q;
    cnt_d        = cnt_q;
    if (accept) begin
      if (blk_end) begin
        left_peak_d  = '0;
        right_peak_d = '0;
        cnt_d        = '0;
      end else begin
        left_peak_d  = l_max;
        right_peak_d = r_max;
        cnt_d        = cnt_inc[spbm_pkg::CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_peak_q  <= '0;
      right_peak_q <= '0;
      cnt_q        <= '0;
    end else begin
      left_peak_q  <= left_peak_d;
      right_peak_q <= right_peak_d;
      cnt_q        <= cnt_d;
    end
  end

endmodule

// ===== rtl/core/spbm_fifo.sv =====
// ----------------------------------------------------------------------------
// Stereo peak bar meter block queue
// Two-entry queue of finished block peaks between front and back end.
// ----------------------------------------------------------------------------
module spbm_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  spbm_pkg::blk_push_t  push_i,
  output logic                 full_o,
  output spbm_pkg::blk_head_t  head_o,
  input  logic                 pop_i
);

  spbm_pkg::blk_t mem_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           do_push, do_pop;

  assign full_o       = cnt_q == 2'd2;
  assign head_o.valid = cnt_q != 2'd0;
  assign head_o.blk   = mem_q[rd_ptr_q];

  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && head_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.blk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ===== rtl/core/spbm_back.sv =====
// ----------------------------------------------------------------------------
// Stereo peak bar meter back end
// Walks the bar segments of one block and registers one request per segment.
// ----------------------------------------------------------------------------
module spbm_back #(
  parameter int unsigned BAR_SEGMENTS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  spbm_pkg::blk_head_t  head_i,
  output logic                 pop_o,
  input  logic [15:0]          low_threshold_i,
  input  logic [15:0]          high_threshold_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output spbm_pkg::out_req_t   out_req_o
);

  localparam int unsigned VW = 23;
  localparam logic [5:0] LAST_IDX = 6'(BAR_SEGMENTS - 1);

  logic [5:0]          idx_q, idx_d;
  logic                out_valid_q, out_valid_d;
  spbm_pkg::out_req_t  out_q, out_d;
  logic                adv, is_last;
  logic [VW-1:0]       pos, lv, rv;
  logic [15:0]         lp, rp;
  logic                l_green, r_green, l_red, r_red, l_yel, r_yel;
  logic                l_lt, r_lt, l_le, r_le;
  logic [1:0]          colour, glyph;

  assign lp  = head_i.blk.left_peak;
  assign rp  = head_i.blk.right_peak;
  assign pos = VW'(idx_q) << 15;
  assign lv  = VW'(lp) * VW'(BAR_SEGMENTS);
  assign rv  = VW'(rp) * VW'(BAR_SEGMENTS);

  assign l_green = lp <= low_threshold_i;
  assign r_green = rp <= low_threshold_i;
  assign l_red   = lp >= high_threshold_i;
  assign r_red   = rp >= high_threshold_i;
  assign l_yel   = (lp > low_threshold_i) && (lp < high_threshold_i);
  assign r_yel   = (rp > low_threshold_i) && (rp < high_threshold_i);
  assign l_lt    = pos < lv;
  assign r_lt    = pos < rv;
  assign l_le    = pos <= lv;
  assign r_le    = pos <= rv;

  always_comb begin
    colour = spbm_pkg::COL_DARK;
    glyph  = spbm_pkg::GLY_BLANK;
    if (l_lt && r_lt && l_green && r_green) begin
      colour = spbm_pkg::COL_GREEN;  glyph = spbm_pkg::GLY_BOTH;
    end else if (l_lt && l_green) begin
      colour = spbm_pkg::COL_GREEN;  glyph = spbm_pkg::GLY_LEFT;
    end else if (r_lt && r_green) begin
      colour = spbm_pkg::COL_GREEN;  glyph = spbm_pkg::GLY_RIGHT;
    end else if (l_le && r_le && l_yel && r_yel) begin
      colour = spbm_pkg::COL_YELLOW; glyph = spbm_pkg::GLY_BOTH;
    end else if (l_le && l_yel) begin
      colour = spbm_pkg::COL_YELLOW; glyph = spbm_pkg::GLY_LEFT;
    end else if (r_le && r_yel) begin
      colour = spbm_pkg::COL_YELLOW; glyph = spbm_pkg::GLY_RIGHT;
    end else if (l_le && r_le && l_red && r_red) begin
      colour = spbm_pkg::COL_RED;    glyph = spbm_pkg::GLY_BOTH;
    end else if (l_le && l_red) begin
      colour = spbm_pkg::COL_RED;    glyph = spbm_pkg::GLY_LEFT;
    end else if (r_le && r_red) begin
      colour = spbm_pkg::COL_RED;    glyph = spbm_pkg::GLY_RIGHT;
    end
  end

  assign is_last = idx_q == LAST_IDX;
  assign adv     = head_i.valid && (!out_valid_q || !out_stall_i);
  assign pop_o   = adv && is_last;

  always_comb begin
    idx_d       = idx_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (adv) begin
      out_valid_d          = 1'b1;
      out_d.segment_index  = idx_q;
      out_d.segment_colour = colour;
      out_d.segment_glyph  = glyph;
      out_d.last_segment   = is_last;
      idx_d                = is_last ? '0 : idx_q + 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

// ===== rtl/core/spbm_checker.sv =====
// ----------------------------------------------------------------------------
// Stereo peak bar meter checker
// Port-level properties of the segment request stream.
// ----------------------------------------------------------------------------
`include "stereo_peak_bar_meter_core_macros.svh"

module spbm_checker #(
  parameter int unsigned BAR_SEGMENTS = 64
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input spbm_pkg::out_req_t                  out_req_o
);

  localparam logic [5:0] LAST_IDX = 6'(BAR_SEGMENTS - 1);

  logic out_take;
  assign out_take = out_valid_o && !out_stall_i;

  `SPBM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(out_req_o), "stalled segment request changed")

  `SPBM_ASSERT_NOW(a_last_flag, clk_i, rst_ni, out_valid_o,
    out_req_o.last_segment == (out_req_o.segment_index == LAST_IDX),
    "last_segment does not match final index")

  `SPBM_ASSERT_NOW(a_dark_blank, clk_i, rst_ni, out_valid_o,
    (out_req_o.segment_colour == spbm_pkg::COL_DARK) ==
    (out_req_o.segment_glyph == spbm_pkg::GLY_BLANK),
    "dark colour and blank glyph disagree")

  `SPBM_ASSERT_NEXT(a_burst_cont, clk_i, rst_ni, out_take && !out_req_o.last_segment,
    out_valid_o && (out_req_o.segment_index == $past(out_req_o.segment_index) + 6'd1),
    "segment burst broken")

endmodule

bind stereo_peak_bar_meter_core spbm_checker #(
  .BAR_SEGMENTS (BAR_SEGMENTS)
) u_spbm_checker (.*);

// ===== sim/stereo_peak_bar_meter_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo peak bar meter core testbench
// Streams stereo Q1.15 frames through the core with bursty input and a
// stalling output side, predicts every bar segment from a local peak and
// zone model, and checks each segment request field by field in order.
// ----------------------------------------------------------------------------
module stereo_peak_bar_meter_core_tb;

  localparam int unsigned NSEG        = 64;
  localparam int unsigned FULL_SCALE  = 32768;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned SETTLE      = 8;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned RAND_FRAMES = 140;

  localparam logic [spbm_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // boundary frames, one bar each
  localparam int DIR_L [14] = '{0, 32767, -32768, -32768, 0, 1, -1,
                                10813, 10814, 21954, 5000, 15000, 512, 21845};
  localparam int DIR_R [14] = '{0, 32767, -32768, 0, -32768, -1, 1,
                                10813, 10814, 21955, 15000, 16000, -16896, -21846};
  // threshold extremes, crossed pairs among them
  localparam int unsigned THR_LO [4] = '{0, 32768, 20000, 32768};
  localparam int unsigned THR_HI [4] = '{0, 32768, 10000, 0};

  logic                            clk_i;
  logic                            rst_ni      = 1'b0;
  logic                            in_valid_i  = 1'b0;
  logic                            in_stall_o;
  spbm_pkg::in_req_t               in_req_i    = '0;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  spbm_pkg::out_req_t              out_req_o;
  logic                            cfg_we_i    = 1'b0;
  logic [spbm_pkg::CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [spbm_pkg::CFG_DATA_W-1:0] cfg_data_i  = '0;

  stereo_peak_bar_meter_core #(
    .BAR_SEGMENTS(NSEG)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_req_o  (out_req_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // predictor state
  logic [spbm_pkg::FPB_W-1:0] fpb_reg   = spbm_pkg::FPB_RESET;
  logic [15:0]                low_thr   = spbm_pkg::LOW_RESET;
  logic [15:0]                high_thr  = spbm_pkg::HIGH_RESET;
  logic [15:0]                left_pk   = '0;
  logic [15:0]                right_pk  = '0;
  logic [spbm_pkg::CNT_W-1:0] frame_cnt = '0;

  spbm_pkg::in_req_t  frame_q[$];
  spbm_pkg::out_req_t segment_q[$];

  int unsigned frames_issued = 0;
  int unsigned frames_taken  = 0;
  int unsigned bars_seen     = 0;
  int unsigned segs_checked  = 0;
  int unsigned reg_writes    = 0;
  int unsigned errors        = 0;
  int unsigned cycle_cnt     = 0;

  logic        in_taken   = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  logic        hold_go    = 1'b0;
  logic        hold_seen  = 1'b0;
  int unsigned hold_left  = 0;
  int unsigned stall_mode = 0;
  int unsigned mode_left  = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    if (errors <= 50)
      $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
  endtask

  function automatic logic [15:0] mag_q15(input logic signed [15:0] s);
    if (s == 16'sh8000) return 16'd32767;
    return s[15] ? 16'(~s + 16'd1) : 16'(s);
  endfunction

  // fold one frame into the peaks; on the block's last frame queue the bar
  task automatic fold_frame(input spbm_pkg::in_req_t f);
    logic [15:0]        lm, rm;
    int unsigned        len, pos, lv, rv;
    logic               lg, rg, ly, ry, lr, rr, llt, rlt, lle, rle;
    spbm_pkg::out_req_t seg;
    lm  = mag_q15(f.left_sample);
    rm  = mag_q15(f.right_sample);
    len = (fpb_reg == '0) ? 1 :
          ((fpb_reg > spbm_pkg::FPB_MAX) ? int'(spbm_pkg::FPB_MAX) : int'(fpb_reg));
    if (lm > left_pk) left_pk = lm;
    if (rm > right_pk) right_pk = rm;
    if (int'(frame_cnt) + 1 < len) begin
      frame_cnt = frame_cnt + 12'd1;
      return;
    end
    lv = int'(left_pk) * NSEG;
    rv = int'(right_pk) * NSEG;
    lg = left_pk <= low_thr;
    rg = right_pk <= low_thr;
    lr = left_pk >= high_thr;
    rr = right_pk >= high_thr;
    ly = left_pk > low_thr && left_pk < high_thr;
    ry = right_pk > low_thr && right_pk < high_thr;
    for (int unsigned i = 0; i < NSEG; i++) begin
      pos = i * FULL_SCALE;
      llt = pos < lv;
      rlt = pos < rv;
      lle = pos <= lv;
      rle = pos <= rv;
      seg.segment_index  = 6'(i);
      seg.last_segment   = (i == NSEG - 1);
      seg.segment_colour = spbm_pkg::COL_DARK;
      seg.segment_glyph  = spbm_pkg::GLY_BLANK;
      if (llt && rlt && lg && rg) begin
        seg.segment_colour = spbm_pkg::COL_GREEN;  seg.segment_glyph = spbm_pkg::GLY_BOTH;
      end else if (llt && lg) begin
        seg.segment_colour = spbm_pkg::COL_GREEN;  seg.segment_glyph = spbm_pkg::GLY_LEFT;
      end else if (rlt && rg) begin
        seg.segment_colour = spbm_pkg::COL_GREEN;  seg.segment_glyph = spbm_pkg::GLY_RIGHT;
      end else if (lle && rle && ly && ry) begin
        seg.segment_colour = spbm_pkg::COL_YELLOW; seg.segment_glyph = spbm_pkg::GLY_BOTH;
      end else if (lle && ly) begin
        seg.segment_colour = spbm_pkg::COL_YELLOW; seg.segment_glyph = spbm_pkg::GLY_LEFT;
      end else if (rle && ry) begin
        seg.segment_colour = spbm_pkg::COL_YELLOW; seg.segment_glyph = spbm_pkg::GLY_RIGHT;
      end else if (lle && rle && lr && rr) begin
        seg.segment_colour = spbm_pkg::COL_RED;    seg.segment_glyph = spbm_pkg::GLY_BOTH;
      end else if (lle && lr) begin
        seg.segment_colour = spbm_pkg::COL_RED;    seg.segment_glyph = spbm_pkg::GLY_LEFT;
      end else if (rle && rr) begin
        seg.segment_colour = spbm_pkg::COL_RED;    seg.segment_glyph = spbm_pkg::GLY_RIGHT;
      end
      segment_q.push_back(seg);
    end
    bars_seen++;
    left_pk   = '0;
    right_pk  = '0;
    frame_cnt = '0;
  endtask

  // monitor: config shadow, frame prediction, segment check
  always @(posedge clk_i) begin
    spbm_pkg::out_req_t want;
    in_taken <= in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          spbm_pkg::REG_FRAMES_PER_BLOCK: fpb_reg  = cfg_data_i[spbm_pkg::FPB_W-1:0];
          spbm_pkg::REG_LOW_THRESHOLD:    low_thr  = cfg_data_i;
          spbm_pkg::REG_HIGH_THRESHOLD:   high_thr = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        frames_taken++;
        fold_frame(in_req_i);
      end
      if (out_valid_o && !out_stall_i) begin
        if (segment_q.size() == 0) begin
          report("segment with no bar pending", 32'(out_req_o.segment_index), 0);
        end else begin
          want = segment_q.pop_front();
          segs_checked++;
          if (out_req_o.segment_index !== want.segment_index)
            report("segment_index", 32'(out_req_o.segment_index),
                   32'(want.segment_index));
          if (out_req_o.segment_colour !== want.segment_colour)
            report("segment_colour", 32'(out_req_o.segment_colour),
                   32'(want.segment_colour));
          if (out_req_o.segment_glyph !== want.segment_glyph)
            report("segment_glyph", 32'(out_req_o.segment_glyph),
                   32'(want.segment_glyph));
          if (out_req_o.last_segment !== want.last_segment)
            report("last_segment", 32'(out_req_o.last_segment),
                   32'(want.last_segment));
        end
      end
    end
  end

  // frame driver: bursts with random gaps
  always @(negedge clk_i) begin
    if (!in_valid_i || in_taken) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (frame_q.size() != 0) begin
        in_req_i   <= frame_q.pop_front();
        in_valid_i <= 1'b1;
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // segment receiver: stall density changes over time, one long hold on request
  always @(negedge clk_i) begin
    if (hold_go && !hold_seen) begin
      hold_seen = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(16, 160);
    end else begin
      mode_left--;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 3) < stall_mode);
    end
  end

  task automatic push_frame(input int l, input int r);
    spbm_pkg::in_req_t f;
    f.left_sample  = 16'(l);
    f.right_sample = 16'(r);
    frame_q.push_back(f);
    frames_issued++;
  endtask

  function automatic int rand_sample();
    int mag;
    case ($urandom_range(0, 5))
      0: return int'($signed(16'($urandom)));
      1: mag = $urandom_range(0, 2047);
      2: mag = $urandom_range(2048, 14000);
      3: mag = $urandom_range(14000, 24000);
      4: mag = $urandom_range(24000, 32767);
      default: return ($urandom_range(0, 1) != 0) ? -32768 : 32767;
    endcase
    return ($urandom_range(0, 1) != 0) ? -mag : mag;
  endfunction

  task automatic push_random_frame();
    int l, r;
    l = rand_sample();
    r = rand_sample();
    case ($urandom_range(0, 7))
      0: l = 0;
      1: r = 0;
      default: ;
    endcase
    push_frame(l, r);
  endtask

  function automatic logic [15:0] rand_level();
    case ($urandom_range(0, 3))
      0: return 16'd0;
      1: return 16'd32768;
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  task automatic write_reg(input logic [spbm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [spbm_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    reg_writes++;
  endtask

  task automatic wait_idle();
    while (frames_taken != frames_issued) @(posedge clk_i);
    while (segment_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  initial begin
    int unsigned rand_done;
    int unsigned ph;
    int unsigned n;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: frames short of the default block, then the length drops
    for (int k = 0; k < 30; k++) push_random_frame();
    wait_idle();
    write_reg(spbm_pkg::REG_FRAMES_PER_BLOCK, 16'd1);
    push_random_frame();
    wait_idle();

    // zero block length acts as one; one bar per boundary frame
    write_reg(spbm_pkg::REG_FRAMES_PER_BLOCK, 16'd0);
    write_reg(spbm_pkg::REG_LOW_THRESHOLD, spbm_pkg::LOW_RESET);
    write_reg(spbm_pkg::REG_HIGH_THRESHOLD, spbm_pkg::HIGH_RESET);
    for (int k = 0; k < 14; k++) push_frame(DIR_L[k], DIR_R[k]);
    wait_idle();

    // threshold extremes and crossed thresholds
    write_reg(spbm_pkg::REG_FRAMES_PER_BLOCK, 16'd1);
    for (int k = 0; k < 4; k++) begin
      write_reg(spbm_pkg::REG_LOW_THRESHOLD, 16'(THR_LO[k]));
      write_reg(spbm_pkg::REG_HIGH_THRESHOLD, 16'(THR_HI[k]));
      push_frame(0, 0);
      push_frame(32767, -32768);
      push_frame(15000, 25000);
      wait_idle();
    end

    // oversized length clamps to the maximum block; a length equal to the
    // count plus one then ends the block on the next frame
    write_reg(spbm_pkg::REG_FRAMES_PER_BLOCK, 16'hFFFF);
    write_reg(spbm_pkg::REG_LOW_THRESHOLD, 16'd8000);
    write_reg(spbm_pkg::REG_HIGH_THRESHOLD, 16'd26000);
    for (int k = 0; k < 40; k++) push_random_frame();
    wait_idle();
    write_reg(spbm_pkg::REG_FRAMES_PER_BLOCK, 16'd41);
    push_random_frame();
    wait_idle();

    // length lowered below the frames already taken
    write_reg(spbm_pkg::REG_FRAMES_PER_BLOCK, 16'd20);
    for (int k = 0; k < 10; k++) push_random_frame();
    wait_idle();
    write_reg(spbm_pkg::REG_FRAMES_PER_BLOCK, 16'd5);
    for (int k = 0; k < 3; k++) push_random_frame();
    wait_idle();

    // random phases; the first one backs up the output for a long stretch
    rand_done = 0;
    ph = 0;
    while (rand_done < RAND_FRAMES) begin
      write_reg(spbm_pkg::REG_FRAMES_PER_BLOCK,
                (ph == 0) ? 16'd1 : 16'($urandom_range(0, 12)));
      if ($urandom_range(0, 3) != 0) write_reg(spbm_pkg::REG_LOW_THRESHOLD, rand_level());
      if ($urandom_range(0, 3) != 0) write_reg(spbm_pkg::REG_HIGH_THRESHOLD, rand_level());
      if ($urandom_range(0, 4) == 0) write_reg(REG_UNUSED, 16'($urandom));
      if (ph == 0) hold_go = 1'b1;
      n = $urandom_range(16, 48);
      for (int unsigned k = 0; k < n; k++) push_random_frame();
      rand_done += n;
      ph++;
      wait_idle();
    end

    repeat (20) @(posedge clk_i);
    $display("covered %0d frames over %0d register writes, %0d bars predicted",
             frames_taken, reg_writes, bars_seen);
    $display("%0d segments checked, %0d mismatches", segs_checked, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
